@@ src/kway_merge_min_heap_top_macros.svh @@
// Assertion macros used by the k-way merge heap datapath
`ifndef KWAY_MERGE_MIN_HEAP_TOP_MACROS_SVH
`define KWAY_MERGE_MIN_HEAP_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define KWM_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KWM_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/kwm_pkg.sv @@
// Package: shared types and codes for the k-way merge heap
`timescale 1ns / 1ps
package kwm_pkg;

    localparam int VAL_W = 32;
    localparam int ID_W  = 4;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_NEXT  = 2'd2,
        CMD_END   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] val;
        logic [ID_W-1:0]         id;
    } entry_t;

    typedef enum logic [2:0] {
        RD_ROOT,
        RD_LAST,
        RD_BUILD,
        RD_LEFT,
        RD_RIGHT
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_LOAD,
        WR_SINK,
        WR_BEST
    } wr_sel_t;

    typedef enum logic [1:0] {
        AT_HOLD,
        AT_ROOT,
        AT_BUILD,
        AT_PICK
    } at_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BUILD,
        S_SINK_LD,
        S_NEXT_LD,
        S_TEST,
        S_CMP_L,
        S_CMP_R,
        S_MOVE,
        S_EMIT,
        S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        at_sel_t at_sel;
        logic    cap_in;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    idx_init;
        logic    idx_dec;
        logic    sink_ld;
        logic    sink_next;
        logic    best_l;
        logic    best_r;
        logic    out_ld;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic count_zero;
        logic count_one;
        logic full;
        logic idx_zero;
        logic l_in;
        logic r_in;
        logic pick_at;
        logic out_free;
    } stat_t;

endpackage

@@ src/kway_merge_min_heap_top.sv @@
// Load: one request a cycle, no result. Next/ended: the result follows the sift-down of the new root,
// which moves down M levels (<= log2 MAX_LISTS); an empty heap, or ending the last entry, skips it.
// Start: sifts down each inner node (heap_count/2 of them) in turn, from the last one to the root.
// One request in flight, ready again in the cycle after the result loads; one memory access a cycle.
// Result waits in an output register; reset (rst_n low) empties the heap, memory contents stay.
`timescale 1ns / 1ps
module kway_merge_min_heap_top #(
    parameter int MAX_LISTS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         cmd,
    input  logic [kwm_pkg::ID_W-1:0]           list_id,
    input  logic signed [kwm_pkg::VAL_W-1:0]   value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [kwm_pkg::VAL_W-1:0]   min_value,
    output logic [kwm_pkg::ID_W-1:0]           min_list,
    output logic                               done_res
);
    import kwm_pkg::*;

    ctl_t  ctl;
    stat_t st;
    cmd_t  cmd_code;

    assign cmd_code = cmd_t'(cmd);

    kwm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd_code),
        .st       (st),
        .ctl      (ctl)
    );

    kwm_datapath #(
        .MAX_LISTS (MAX_LISTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .st        (st),
        .list_id   (list_id),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .min_value (min_value),
        .min_list  (min_list),
        .done_res  (done_res)
    );

endmodule

@@ src/kwm_ctrl.sv @@
// Controller state machine: sequences load, heapify, sift-down and emit
`timescale 1ns / 1ps
module kwm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  kwm_pkg::cmd_t  cmd,
    input  kwm_pkg::stat_t st,
    output kwm_pkg::ctl_t  ctl
);
    import kwm_pkg::*;

    state_t state_reg, state_next;
    logic   build_reg, build_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            build_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            build_reg <= build_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        build_next = build_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.cap_in = 1'b1;
                    case (cmd)
                        CMD_LOAD:
                        begin
                            if (!st.full)
                            begin
                                ctl.wr_en   = 1'b1;
                                ctl.wr_sel  = WR_LOAD;
                                ctl.cnt_inc = 1'b1;
                            end
                        end
                        CMD_START:
                        begin
                            ctl.idx_init = 1'b1;
                            build_next   = 1'b1;
                            state_next   = S_BUILD;
                        end
                        CMD_NEXT:
                        begin
                            build_next = 1'b0;
                            if (st.count_zero)
                                state_next = S_EMIT;
                            else
                            begin
                                ctl.rd_en  = 1'b1;
                                ctl.rd_sel = RD_ROOT;
                                ctl.at_sel = AT_ROOT;
                                state_next = S_NEXT_LD;
                            end
                        end
                        CMD_END:
                        begin
                            build_next = 1'b0;
                            if (st.count_zero)
                                state_next = S_EMIT;
                            else
                            begin
                                ctl.cnt_dec = 1'b1;
                                if (st.count_one)
                                    state_next = S_EMIT;
                                else
                                begin
                                    // last entry becomes the sinking root
                                    ctl.rd_en  = 1'b1;
                                    ctl.rd_sel = RD_LAST;
                                    ctl.at_sel = AT_ROOT;
                                    state_next = S_SINK_LD;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_BUILD:
            begin
                if (st.idx_zero)
                    state_next = S_EMIT;
                else
                begin
                    ctl.idx_dec = 1'b1;
                    ctl.rd_en   = 1'b1;
                    ctl.rd_sel  = RD_BUILD;
                    ctl.at_sel  = AT_BUILD;
                    state_next  = S_SINK_LD;
                end
            end
            S_SINK_LD:
            begin
                ctl.sink_ld = 1'b1;
                state_next  = S_TEST;
            end
            S_NEXT_LD:
            begin
                ctl.sink_ld   = 1'b1;
                ctl.sink_next = 1'b1;
                state_next    = S_TEST;
            end
            S_TEST:
            begin
                if (!st.l_in)
                begin
                    ctl.wr_en  = 1'b1;
                    ctl.wr_sel = WR_SINK;
                    state_next = build_reg ? S_BUILD : S_EMIT;
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RD_LEFT;
                    state_next = S_CMP_L;
                end
            end
            S_CMP_L:
            begin
                ctl.best_l = 1'b1;
                if (st.r_in)
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RD_RIGHT;
                    state_next = S_CMP_R;
                end
                else
                    state_next = S_MOVE;
            end
            S_CMP_R:
            begin
                ctl.best_r = 1'b1;
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                ctl.wr_en = 1'b1;
                if (st.pick_at)
                begin
                    ctl.wr_sel = WR_SINK;
                    state_next = build_reg ? S_BUILD : S_EMIT;
                end
                else
                begin
                    // smaller child moves up, sinking entry goes one level down
                    ctl.wr_sel = WR_BEST;
                    ctl.at_sel = AT_PICK;
                    state_next = S_TEST;
                end
            end
            S_EMIT:
            begin
                ctl.rd_en  = 1'b1;
                ctl.rd_sel = RD_ROOT;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (st.out_free)
                begin
                    ctl.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/kwm_datapath.sv @@
// Datapath: heap memory, count, sift registers, compare and output register
`timescale 1ns / 1ps
`include "kway_merge_min_heap_top_macros.svh"
module kwm_datapath #(
    parameter int MAX_LISTS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  kwm_pkg::ctl_t                      ctl,
    output kwm_pkg::stat_t                     st,
    input  logic [kwm_pkg::ID_W-1:0]           list_id,
    input  logic signed [kwm_pkg::VAL_W-1:0]   value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [kwm_pkg::VAL_W-1:0]   min_value,
    output logic [kwm_pkg::ID_W-1:0]           min_list,
    output logic                               done_res
);
    import kwm_pkg::*;

    localparam int IDX_W = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
    localparam int CNT_W = $clog2(MAX_LISTS + 1);
    localparam int CH_W  = IDX_W + 2;

    entry_t heap_mem [MAX_LISTS];

    entry_t                  rd_data_reg;
    entry_t                  sink_reg;
    entry_t                  best_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [IDX_W-1:0]        at_reg, at_next;
    logic [IDX_W-1:0]        pick_reg, pick_next;
    logic                    out_valid_reg;
    logic signed [VAL_W-1:0] min_value_reg;
    logic [ID_W-1:0]         min_list_reg;
    logic                    done_reg;

    logic [CH_W-1:0]  l_wide, r_wide, cnt_wide;
    logic [CNT_W-1:0] cnt_m1, idx_m1;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    entry_t           wr_data;
    logic             lt_l, lt_r;

    assign l_wide   = {1'b0, at_reg, 1'b1};
    assign r_wide   = l_wide + CH_W'(1);
    assign cnt_wide = CH_W'(cnt_reg);
    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign idx_m1   = idx_reg - CNT_W'(1);

    assign lt_l = $signed(rd_data_reg.val) < $signed(sink_reg.val);
    assign lt_r = $signed(rd_data_reg.val) < $signed(best_reg.val);

    always_comb
    begin
        case (ctl.rd_sel)
            RD_ROOT:  rd_addr = '0;
            RD_LAST:  rd_addr = cnt_m1[IDX_W-1:0];
            RD_BUILD: rd_addr = idx_m1[IDX_W-1:0];
            RD_LEFT:  rd_addr = l_wide[IDX_W-1:0];
            RD_RIGHT: rd_addr = r_wide[IDX_W-1:0];
            default:  rd_addr = '0;
        endcase
    end

    always_comb
    begin
        case (ctl.wr_sel)
            WR_LOAD:
            begin
                wr_addr = cnt_reg[IDX_W-1:0];
                wr_data = '{val: value, id: list_id};
            end
            WR_SINK:
            begin
                wr_addr = at_reg;
                wr_data = sink_reg;
            end
            WR_BEST:
            begin
                wr_addr = at_reg;
                wr_data = best_reg;
            end
            default:
            begin
                wr_addr = at_reg;
                wr_data = sink_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
            heap_mem[wr_addr] <= wr_data;
        if (ctl.rd_en)
            rd_data_reg <= heap_mem[rd_addr];
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.cnt_inc)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (ctl.cnt_dec)
            cnt_next = cnt_m1;

        idx_next = idx_reg;
        if (ctl.idx_init)
            idx_next = cnt_reg >> 1;
        else if (ctl.idx_dec)
            idx_next = idx_m1;

        case (ctl.at_sel)
            AT_HOLD:  at_next = at_reg;
            AT_ROOT:  at_next = '0;
            AT_BUILD: at_next = idx_m1[IDX_W-1:0];
            AT_PICK:  at_next = pick_reg;
            default:  at_next = at_reg;
        endcase

        pick_next = pick_reg;
        if (ctl.best_l)
            pick_next = lt_l ? l_wide[IDX_W-1:0] : at_reg;
        else if (ctl.best_r && lt_r)
            pick_next = r_wide[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            idx_reg       <= '0;
            at_reg        <= '0;
            pick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            idx_reg  <= idx_next;
            at_reg   <= at_next;
            pick_reg <= pick_next;
            if (ctl.out_ld)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cap_in)
            val_reg <= value;
        if (ctl.sink_ld)
        begin
            if (ctl.sink_next)
                sink_reg <= '{val: val_reg, id: rd_data_reg.id};
            else
                sink_reg <= rd_data_reg;
        end
        if (ctl.best_l)
            best_reg <= lt_l ? rd_data_reg : sink_reg;
        else if (ctl.best_r && lt_r)
            best_reg <= rd_data_reg;
        if (ctl.out_ld)
        begin
            done_reg <= (cnt_reg == '0);
            if (cnt_reg == '0)
            begin
                min_value_reg <= '0;
                min_list_reg  <= '0;
            end
            else
            begin
                min_value_reg <= rd_data_reg.val;
                min_list_reg  <= rd_data_reg.id;
            end
        end
    end

    assign st.count_zero = (cnt_reg == '0);
    assign st.count_one  = (cnt_reg == CNT_W'(1));
    assign st.full       = (cnt_reg == CNT_W'(MAX_LISTS));
    assign st.idx_zero   = (idx_reg == '0);
    assign st.l_in       = (l_wide < cnt_wide);
    assign st.r_in       = (r_wide < cnt_wide);
    assign st.pick_at    = (pick_reg == at_reg);
    assign st.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign min_value = min_value_reg;
    assign min_list  = min_list_reg;
    assign done_res  = done_reg;

    `KWM_ASSERT_IMP(a_cnt_max, 1'b1, cnt_reg <= CNT_W'(MAX_LISTS), "heap count above capacity")
    `KWM_ASSERT_IMP(a_sift_wr_in_heap, ctl.wr_en && ctl.wr_sel != WR_LOAD, CNT_W'(at_reg) < cnt_reg, "sift write outside heap")
    `KWM_ASSERT_IMP(a_done_zero, out_valid_reg && done_reg, min_value == '0 && min_list == '0, "done result carries data")
    `KWM_ASSERT_NXT(a_cnt_inc, ctl.cnt_inc, cnt_reg == $past(cnt_reg) + CNT_W'(1), "load did not grow heap")
    `KWM_ASSERT_IMP(a_out_ld_free, ctl.out_ld, !out_valid_reg || out_ready, "result register overwritten")

endmodule
